[src/hall_edge_speed_estimator_assert.svh]
// Assertion macros shared by the estimator modules.
// Each use needs clk and rst_n in scope.
`ifndef HALL_EDGE_SPEED_ESTIMATOR_ASSERT_SVH
`define HALL_EDGE_SPEED_ESTIMATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define HESE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hall_edge_speed_estimator: check failed");
`define HESE_NEVER(lbl, cond) `HESE_ASSERT(lbl, !(cond))
`else
`define HESE_ASSERT(lbl, prop)
`define HESE_NEVER(lbl, cond)
`endif

`endif

[src/hesp_pkg.sv]
package hesp_pkg;

  localparam int SPEED_W   = 26;
  localparam int GAIN_W    = 24;
  localparam int POS_W     = 48;
  localparam int HALL_W    = 3;
  localparam int TICK_W    = 16;
  localparam int REQ_W     = 3;
  localparam int CAPTURE_W = 16;
  localparam int PROD_W    = SPEED_W + GAIN_W;

  localparam int PERIOD_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int OUT_DATA_W = ((SPEED_W + POS_W + HALL_W + TICK_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SPEED_W;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INT_GAIN  = 2'd1;

  localparam logic [SPEED_W-1:0] SPEED_NUM_RST = 26'd41888000;
  localparam logic [GAIN_W-1:0]  INT_GAIN_RST  = 24'd1678;
  localparam logic [SPEED_W-1:0] SPEED_MAX     = {SPEED_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MAX       = {POS_W{1'b1}};

  localparam logic [REQ_W-1:0] REQ_EDGE_A  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_EDGE_B  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_EDGE_C  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TIMEOUT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd4;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SPEED,
    OP_CLEAR,
    OP_INTEG
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [HALL_W-1:0] hall;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_MUL,
    B_ADD,
    B_EMIT
  } back_state_t;

endpackage

[src/hall_edge_speed_estimator.sv]
// Hall-edge speed and position estimator.
// Input channel in_*: one request per transfer. in_tuser carries the request
// kind (edge A, edge B, edge C, stall timeout, integration tick), in_tdata the
// captured timer period, which only edges use. Every request gives exactly one
// result on out_*: speed, position, kept hall flags and tick count in
// out_tdata, and out_tuser set when an edge recomputed speed.
// cfg_we/cfg_index/cfg_data write the speed numerator (index 0) and the
// integration gain (index 1); write them only while no request is in flight.
// A front stage classifies each request and toggles the hall flags; a
// four-entry queue feeds the back stage that does the arithmetic.
// From accept to result: a timeout, a zero period or a non-forward edge go
// straight to the result; an integration tick takes a multiply, then a
// saturating add; a forward edge with nonzero period runs the radix-2
// divider that makes one quotient bit per cycle over 26 bits. The back stage
// takes one request at a time and pops the next once the result is loaded.
// Reset clears flags, speed, position, tick count and restores both registers.
// When out_tready is low the result is held; the queue keeps taking requests
// until it fills, then in_tready drops.
module hall_edge_speed_estimator import hesp_pkg::*; #(
  parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CAPTURE_W-1:0]  in_tdata,   // capture_period
  input  logic [REQ_W-1:0]      in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // speed_q8, position_q32, hall_state, tick_count, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // speed_updated
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW = (PERIOD_BITS < CAPTURE_W) ? PERIOD_BITS : CAPTURE_W;
  localparam int QW = $bits(cmd_t) + PW;

  logic [SPEED_W-1:0] speed_num_r;
  logic [GAIN_W-1:0]  int_gain_r;

  logic          q_full;
  logic          q_empty;
  logic          q_push;
  logic          q_pop;
  cmd_t          push_cmd;
  logic [PW-1:0] push_period;
  cmd_t          pop_cmd;
  logic [PW-1:0] pop_period;
  logic [QW-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_num_r <= SPEED_NUM_RST;
      int_gain_r  <= INT_GAIN_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SPEED_NUM) begin
        speed_num_r <= cfg_data[SPEED_W-1:0];
      end else if (cfg_index == CFG_INT_GAIN) begin
        int_gain_r <= cfg_data[GAIN_W-1:0];
      end
    end
  end

  hesp_front #(.PW(PW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd),
    .q_period  (push_period)
  );

  hesp_queue #(.DEPTH(QUEUE_DEPTH), .W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({push_cmd, push_period}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign pop_cmd    = q_rdata[QW-1:PW];
  assign pop_period = q_rdata[PW-1:0];

  hesp_back #(.PW(PW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (!q_empty),
    .q_cmd      (pop_cmd),
    .q_period   (pop_period),
    .q_pop      (q_pop),
    .speed_num  (speed_num_r),
    .int_gain   (int_gain_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[src/hesp_front.sv]
module hesp_front import hesp_pkg::*; #(
  parameter int PW = PERIOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [CAPTURE_W-1:0] in_tdata,   // capture_period
  input  logic [REQ_W-1:0]     in_tuser,   // req_type
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd,
  output logic [PW-1:0]        q_period
);

  logic [HALL_W-1:0] flags_r;
  logic [HALL_W-1:0] flags_nxt;
  logic              fwd;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;
  assign q_period  = in_tdata[PW-1:0];

  // toggle the channel's flag, then check for a forward step
  always_comb begin
    flags_nxt = flags_r;
    fwd       = 1'b0;
    unique case (in_tuser)
      REQ_EDGE_A: begin
        flags_nxt = flags_r ^ 3'b100;
        fwd       = (flags_nxt == 3'b110) || (flags_nxt == 3'b001);
      end
      REQ_EDGE_B: begin
        flags_nxt = flags_r ^ 3'b010;
        fwd       = (flags_nxt == 3'b100) || (flags_nxt == 3'b011);
      end
      REQ_EDGE_C: begin
        flags_nxt = flags_r ^ 3'b001;
        fwd       = (flags_nxt == 3'b101) || (flags_nxt == 3'b010);
      end
      default: begin
        flags_nxt = flags_r;
        fwd       = 1'b0;
      end
    endcase
  end

  always_comb begin
    q_cmd.hall = flags_nxt;
    unique case (in_tuser)
      REQ_EDGE_A, REQ_EDGE_B, REQ_EDGE_C: q_cmd.op = fwd ? OP_SPEED : OP_HOLD;
      REQ_TIMEOUT:                        q_cmd.op = OP_CLEAR;
      REQ_TICK:                           q_cmd.op = OP_INTEG;
      default:                            q_cmd.op = OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (q_push) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

[src/hesp_queue.sv]
`include "hall_edge_speed_estimator_assert.svh"

module hesp_queue import hesp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH,
  parameter int W     = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `HESE_NEVER(a_q_no_overflow, push && full && !pop)
  `HESE_NEVER(a_q_no_underflow, pop && empty)
  `HESE_ASSERT(a_q_count_range, count_r <= CNT_W'(DEPTH))

endmodule

[src/hesp_back.sv]
`include "hall_edge_speed_estimator_assert.svh"

module hesp_back import hesp_pkg::*; #(
  parameter int PW = PERIOD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  input  logic [PW-1:0]         q_period,
  output logic                  q_pop,
  input  logic [SPEED_W-1:0]    speed_num,
  input  logic [GAIN_W-1:0]     int_gain,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // speed_q8, position_q32, hall_state, tick_count, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser  // speed_updated
);

  localparam int CNT_W = $clog2(SPEED_W);
  localparam int PAD_W = OUT_DATA_W - (SPEED_W + POS_W + HALL_W + TICK_W);

  back_state_t state_r;
  back_state_t state_nxt;

  logic [SPEED_W-1:0] speed_r;
  logic [POS_W-1:0]   pos_r;
  logic [TICK_W-1:0]  tick_r;
  logic               out_valid_r;

  logic [HALL_W-1:0]  hall_r;
  logic               upd_r;
  logic [PW-1:0]      div_r;
  logic [PW-1:0]      rem_r;
  logic [SPEED_W-1:0] quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]  prod_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  logic            out_load;
  logic            div_last;
  logic [PW:0]     shifted;
  logic [PW:0]     diff;
  logic            ge;
  logic [PW-1:0]   rem_nxt;
  logic [POS_W+2:0] pos_sum;

  // one restoring quotient bit per cycle; the borrow bit tells whether to subtract
  assign shifted  = {rem_r, quo_r[SPEED_W-1]};
  assign diff     = shifted - {1'b0, div_r};
  assign ge       = !diff[PW];
  assign rem_nxt  = ge ? diff[PW-1:0] : shifted[PW-1:0];
  assign div_last = (cnt_r == CNT_W'(SPEED_W - 1));
  assign pos_sum  = {3'b000, pos_r} + {1'b0, prod_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_SPEED: state_nxt = (q_period == '0) ? B_EMIT : B_DIV;
            OP_INTEG: state_nxt = B_MUL;
            default:  state_nxt = B_EMIT;
          endcase
        end
      end
      B_DIV:   state_nxt = div_last ? B_EMIT : B_DIV;
      B_MUL:   state_nxt = B_ADD;
      B_ADD:   state_nxt = B_EMIT;
      B_EMIT:  state_nxt = (!out_valid_r || out_tready) ? B_IDLE : B_EMIT;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == B_IDLE) && q_valid;
    out_load = (state_r == B_EMIT) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      speed_r     <= '0;
      pos_r       <= '0;
      tick_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_cmd.op == OP_SPEED && q_period == '0) begin
          speed_r <= SPEED_MAX;
        end else if (q_cmd.op == OP_CLEAR) begin
          speed_r <= '0;
        end
      end
      if (state_r == B_DIV && div_last) begin
        speed_r <= {quo_r[SPEED_W-2:0], ge};
      end
      if (state_r == B_ADD) begin
        pos_r  <= (pos_sum[POS_W+2:POS_W] != 3'b000) ? POS_MAX : pos_sum[POS_W-1:0];
        tick_r <= tick_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      hall_r <= q_cmd.hall;
      upd_r  <= (q_cmd.op == OP_SPEED);
      div_r  <= q_period;
      rem_r  <= '0;
      quo_r  <= speed_num;
      cnt_r  <= '0;
    end else if (state_r == B_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[SPEED_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == B_MUL) begin
      prod_r <= speed_r * int_gain;
    end
    if (out_load) begin
      out_data_r <= {{PAD_W{1'b0}}, tick_r, hall_r, pos_r, speed_r};
      out_user_r <= upd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `HESE_NEVER(a_div_nonzero, (state_r == B_DIV) && (div_r == '0))
  `HESE_ASSERT(a_mul_then_add, (state_r == B_MUL) |=> (state_r == B_ADD))
  `HESE_NEVER(a_pop_only_idle, q_pop && (state_r != B_IDLE))

endmodule
